[hw/rtl/lfgi_pkg.sv]
// Package for the log-frequency gain interpolator.
// Holds sizes, codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package lfgi_pkg;

    localparam int MAX_NODES = 256;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int IDX_W     = 8;
    localparam int FREQ_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int EXP_W     = 5;
    localparam int FRAC_W    = 16;
    localparam int LOG_W     = EXP_W + FRAC_W;
    localparam int MANT_W    = 31;
    localparam int PROD_W    = 2 * MANT_W;
    localparam int DIFF_W    = GAIN_W + 1;
    localparam int MUL_W     = LOG_W + 1 + DIFF_W;
    localparam int DIV_W     = MUL_W - 1;
    localparam int DCNT_W    = $clog2(DIV_W);
    localparam int QUO_W     = GAIN_W + 1;
    localparam int SUM_W     = GAIN_W + 3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

    typedef enum logic [1:0] {
        REG_EMPTY  = 2'd0,
        REG_BELOW  = 2'd1,
        REG_ABOVE  = 2'd2,
        REG_INTERP = 2'd3
    } region_t;

    typedef enum logic [1:0] {
        RA_R,
        RA_RM1,
        RA_CM1
    } raddr_sel_t;

    typedef enum logic [2:0] {
        RS_EMPTY,
        RS_RDGAIN,
        RS_GL,
        RS_GR,
        RS_INTERP
    } res_sel_t;

    typedef enum logic [1:0] {
        LS_LEFT,
        LS_RIGHT,
        LS_QUERY
    } log_sel_t;

    typedef struct packed {
        logic       wr_node;
        logic       ld_query;
        logic       r_clr;
        logic       r_inc;
        raddr_sel_t raddr_sel;
        logic       save_right;
        logic       save_left;
        logic       log_start;
        log_sel_t   log_sel;
        logic       mul;
        logic       div_start;
        logic       res_load;
        res_sel_t   res_sel;
        region_t    res_region;
        logic       out_load;
    } lfgi_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic r_at_cnt;
        logic r_zero;
        logic freq_ge_q;
        logic gains_eq;
        logic log_done;
        logic lr_le_ll;
        logic div_done;
        logic out_busy;
    } lfgi_sts_t;

endpackage

[hw/rtl/lfgi_if.sv]
// Valid/ready channel interfaces for the gain interpolator input and output.
// Depends on lfgi_pkg for field widths.
`timescale 1ns / 1ps

interface lfgi_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [lfgi_pkg::IDX_W-1:0]           node_index;
    logic [lfgi_pkg::FREQ_W-1:0]          node_freq;
    logic signed [lfgi_pkg::GAIN_W-1:0]   node_gain;
    logic [lfgi_pkg::FREQ_W-1:0]          query_freq;

    modport source (output valid, action, node_index, node_freq, node_gain, query_freq,
                    input ready);
    modport sink (input valid, action, node_index, node_freq, node_gain, query_freq,
                  output ready);
endinterface

interface lfgi_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lfgi_pkg::GAIN_W-1:0] gain;
    logic [1:0]                         region;

    modport source (output valid, gain, region, input ready);
    modport sink (input valid, gain, region, output ready);
endinterface

[hw/rtl/log_freq_gain_interpolator.sv]
// Top level of the log-frequency gain interpolator.
// Joins lfgi_ctrl and lfgi_dp; depends on lfgi_pkg and the lfgi_in_if/lfgi_out_if channels.
`timescale 1ns / 1ps

// The block keeps a table of up to 256 nodes (frequency Q24.8 Hz, gain Q8.8 dB).
// Every transaction on the input channel is either a node load (action 0) or a
// gain query (action 1). A load writes both tables in the cycle it is accepted
// and produces no output transaction. A query produces exactly one output
// transaction with the interpolated gain and a region code.
// The node count comes from the configuration port (cfg_we, cfg_wdata); it is to be
// written only while the block is idle, which the block itself does not enforce.
// A query is worked through one step at a time: the table scan examines one
// node at a time with a registered RAM read followed by a compare. A query
// that interpolates adds three log2 evaluations in the shared log unit (16
// squarings, each a multiply phase and a normalize phase), one multiply step
// and a restoring divide.
// The result sits in an output register; while the receiver stalls, the block
// keeps taking loads and starts the next query, which then waits at its end
// until the output register is free.
// Reset clears the node count and all control state; table contents are
// undefined until loaded.

module log_freq_gain_interpolator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lfgi_pkg::CNT_W-1:0]  cfg_wdata,
    lfgi_in_if.sink                     in_ch,
    lfgi_out_if.source                  out_ch
);

    lfgi_pkg::lfgi_cmd_t cmd;
    lfgi_pkg::lfgi_sts_t sts;

    // The controller owns the input handshake and sequences every query.
    lfgi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the tables, arithmetic units and the output register.
    lfgi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .node_index (in_ch.node_index),
        .node_freq  (in_ch.node_freq),
        .node_gain  (in_ch.node_gain),
        .query_freq (in_ch.query_freq),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_gain   (out_ch.gain),
        .out_region (out_ch.region)
    );

endmodule

[hw/rtl/lfgi_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lfgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lfgi_ctrl.sv]
// Controller state machine of the gain interpolator.
// Sequences table scan, log evaluation, division and result hand-off; uses lfgi_pkg.
`timescale 1ns / 1ps

module lfgi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_action,
    output logic                in_ready,
    output lfgi_pkg::lfgi_cmd_t cmd,
    input  lfgi_pkg::lfgi_sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_LAST_RD, S_LAST_CMP, S_LEFT_RD, S_LEFT_CMP,
        S_CHK, S_LOG_L, S_LOG_R, S_LOG_Q, S_CHK2, S_MUL, S_DIV_GO, S_DIV, S_INTERP, S_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.raddr_sel  = lfgi_pkg::RA_R;
        cmd.log_sel    = lfgi_pkg::LS_LEFT;
        cmd.res_sel    = lfgi_pkg::RS_EMPTY;
        cmd.res_region = lfgi_pkg::REG_EMPTY;
        in_ready       = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_action)
                begin
                    cmd.wr_node = 1'b1;
                end
                else if (in_valid && in_action)
                begin
                    cmd.ld_query = 1'b1;
                    cmd.r_clr    = 1'b1;
                    if (sts.cnt_zero)
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_PUT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = sts.r_at_cnt ? S_LAST_RD : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.freq_ge_q && sts.r_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_sel    = lfgi_pkg::RS_RDGAIN;
                    cmd.res_region = lfgi_pkg::REG_BELOW;
                    state_next     = S_PUT;
                end
                else if (sts.freq_ge_q)
                begin
                    cmd.save_right = 1'b1;
                    state_next     = S_LEFT_RD;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_LAST_RD:
            begin
                cmd.raddr_sel = lfgi_pkg::RA_CM1;
                state_next    = S_LAST_CMP;
            end
            S_LAST_CMP:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_sel    = lfgi_pkg::RS_RDGAIN;
                cmd.res_region = lfgi_pkg::REG_ABOVE;
                state_next     = S_PUT;
            end
            S_LEFT_RD:
            begin
                cmd.raddr_sel = lfgi_pkg::RA_RM1;
                state_next    = S_LEFT_CMP;
            end
            S_LEFT_CMP:
            begin
                cmd.save_left = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK:
            begin
                if (sts.gains_eq)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_sel    = lfgi_pkg::RS_GL;
                    cmd.res_region = lfgi_pkg::REG_INTERP;
                    state_next     = S_PUT;
                end
                else
                begin
                    cmd.log_start = 1'b1;
                    cmd.log_sel   = lfgi_pkg::LS_LEFT;
                    state_next    = S_LOG_L;
                end
            end
            S_LOG_L:
            begin
                if (sts.log_done)
                begin
                    cmd.log_start = 1'b1;
                    cmd.log_sel   = lfgi_pkg::LS_RIGHT;
                    state_next    = S_LOG_R;
                end
            end
            S_LOG_R:
            begin
                if (sts.log_done)
                begin
                    cmd.log_start = 1'b1;
                    cmd.log_sel   = lfgi_pkg::LS_QUERY;
                    state_next    = S_LOG_Q;
                end
            end
            S_LOG_Q:
            begin
                if (sts.log_done)
                begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                if (sts.lr_le_ll)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_sel    = lfgi_pkg::RS_GR;
                    cmd.res_region = lfgi_pkg::REG_INTERP;
                    state_next     = S_PUT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_INTERP;
                end
            end
            S_INTERP:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_sel    = lfgi_pkg::RS_INTERP;
                cmd.res_region = lfgi_pkg::REG_INTERP;
                state_next     = S_PUT;
            end
            S_PUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lfgi_dp.sv]
// Datapath of the gain interpolator: node tables, scan pointer, iterative log2,
// multiplier, restoring divider and output register. Uses lfgi_pkg and lfgi_ram.
`timescale 1ns / 1ps

module lfgi_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lfgi_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic [lfgi_pkg::IDX_W-1:0]          node_index,
    input  logic [lfgi_pkg::FREQ_W-1:0]         node_freq,
    input  logic signed [lfgi_pkg::GAIN_W-1:0]  node_gain,
    input  logic [lfgi_pkg::FREQ_W-1:0]         query_freq,
    input  lfgi_pkg::lfgi_cmd_t                 cmd,
    output lfgi_pkg::lfgi_sts_t                 sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [lfgi_pkg::GAIN_W-1:0]  out_gain,
    output logic [1:0]                          out_region
);

    // Configuration and scan state.
    logic [lfgi_pkg::CNT_W-1:0]  node_count_reg;
    logic [lfgi_pkg::CNT_W-1:0]  cnt;
    logic [lfgi_pkg::CNT_W-1:0]  r_reg;
    logic [lfgi_pkg::CNT_W-1:0]  r_m1;
    logic [lfgi_pkg::CNT_W-1:0]  cnt_m1;
    logic [lfgi_pkg::ADDR_W-1:0] raddr;
    logic                        wr_en;
    logic [lfgi_pkg::FREQ_W-1:0] freq_rd;
    logic [lfgi_pkg::GAIN_W-1:0] gain_rd;

    logic [lfgi_pkg::FREQ_W-1:0]        q_reg;
    logic [lfgi_pkg::FREQ_W-1:0]        fl_reg;
    logic [lfgi_pkg::FREQ_W-1:0]        fr_reg;
    logic signed [lfgi_pkg::GAIN_W-1:0] gl_reg;
    logic signed [lfgi_pkg::GAIN_W-1:0] gr_reg;

    // Log2 unit.
    logic                         log_busy_reg;
    logic                         log_phase_reg;
    logic [3:0]                   log_iter_reg;
    lfgi_pkg::log_sel_t           log_sel_reg;
    logic [lfgi_pkg::EXP_W-1:0]   log_e_reg;
    logic [lfgi_pkg::FRAC_W-1:0]  log_frac_reg;
    logic [lfgi_pkg::MANT_W-1:0]  log_y_reg;
    logic [lfgi_pkg::PROD_W-1:0]  log_prod_reg;
    logic [lfgi_pkg::FREQ_W-1:0]  log_x;
    logic [lfgi_pkg::FREQ_W-1:0]  log_xn;
    logic [lfgi_pkg::EXP_W-1:0]   log_e;
    logic [lfgi_pkg::FREQ_W-1:0]  log_mant;
    logic [lfgi_pkg::FREQ_W-1:0]  log_sq;
    logic                         log_bit;
    logic [lfgi_pkg::MANT_W-1:0]  log_y_next;
    logic                         log_done;
    logic [lfgi_pkg::LOG_W-1:0]   log_result;
    logic [lfgi_pkg::LOG_W-1:0]   ll_reg;
    logic [lfgi_pkg::LOG_W-1:0]   lr_reg;
    logic [lfgi_pkg::LOG_W-1:0]   lq_reg;

    // Multiply and divide.
    logic [lfgi_pkg::LOG_W-1:0]         den;
    logic [lfgi_pkg::LOG_W-1:0]         num;
    logic signed [lfgi_pkg::DIFF_W-1:0] diff;
    logic signed [lfgi_pkg::MUL_W-1:0]  p_reg;
    logic [lfgi_pkg::DIV_W-1:0]         p_mag;
    logic                               div_busy_reg;
    logic [lfgi_pkg::DCNT_W-1:0]        div_cnt_reg;
    logic [lfgi_pkg::LOG_W:0]           rem_reg;
    logic [lfgi_pkg::DIV_W-1:0]         quo_reg;
    logic [lfgi_pkg::LOG_W:0]           trial;
    logic                               trial_ge;
    logic                               div_done;

    // Result.
    logic [lfgi_pkg::QUO_W-1:0]         d_mag;
    logic signed [lfgi_pkg::SUM_W-1:0]  sum;
    logic signed [lfgi_pkg::GAIN_W-1:0] interp;
    logic signed [lfgi_pkg::GAIN_W-1:0] res_gain_reg;
    logic [1:0]                         res_region_reg;
    logic signed [lfgi_pkg::GAIN_W-1:0] res_gain;
    logic                               out_valid_reg;
    logic signed [lfgi_pkg::GAIN_W-1:0] out_gain_reg;
    logic [1:0]                         out_region_reg;

    assign cnt    = (node_count_reg > lfgi_pkg::MAX_CNT) ? lfgi_pkg::MAX_CNT : node_count_reg;
    assign r_m1   = r_reg - 1'b1;
    assign cnt_m1 = cnt - 1'b1;
    assign wr_en  = cmd.wr_node &&
                    (lfgi_pkg::CNT_W'(node_index) < lfgi_pkg::MAX_CNT);

    always_comb
    begin
        unique case (cmd.raddr_sel)
            lfgi_pkg::RA_RM1: raddr = r_m1[lfgi_pkg::ADDR_W-1:0];
            lfgi_pkg::RA_CM1: raddr = cnt_m1[lfgi_pkg::ADDR_W-1:0];
            default:          raddr = r_reg[lfgi_pkg::ADDR_W-1:0];
        endcase
    end

    lfgi_ram #(.WIDTH(lfgi_pkg::FREQ_W), .DEPTH(lfgi_pkg::MAX_NODES)) u_freq_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (node_index[lfgi_pkg::ADDR_W-1:0]),
        .wdata (node_freq),
        .raddr (raddr),
        .rdata (freq_rd)
    );

    lfgi_ram #(.WIDTH(lfgi_pkg::GAIN_W), .DEPTH(lfgi_pkg::MAX_NODES)) u_gain_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (node_index[lfgi_pkg::ADDR_W-1:0]),
        .wdata (node_gain),
        .raddr (raddr),
        .rdata (gain_rd)
    );

    // Log2 input selection and normalization: exponent is the leading one position.
    always_comb
    begin
        unique case (cmd.log_sel)
            lfgi_pkg::LS_RIGHT: log_x = fr_reg;
            lfgi_pkg::LS_QUERY: log_x = q_reg;
            default:            log_x = fl_reg;
        endcase
        log_xn = (log_x == '0) ? lfgi_pkg::FREQ_W'(1) : log_x;
        log_e  = '0;
        for (int i = 0; i < lfgi_pkg::FREQ_W; i++)
        begin
            if (log_xn[i])
            begin
                log_e = lfgi_pkg::EXP_W'(i);
            end
        end
        log_mant = log_xn << (lfgi_pkg::EXP_W'(lfgi_pkg::FREQ_W - 1) - log_e);
    end

    // Squaring step: the product is truncated back to Q1.30 and renormalized.
    assign log_sq     = log_prod_reg[lfgi_pkg::PROD_W-1:lfgi_pkg::MANT_W-1];
    assign log_bit    = log_sq[lfgi_pkg::FREQ_W-1];
    assign log_y_next = log_bit ? log_sq[lfgi_pkg::FREQ_W-1:1]
                                : log_sq[lfgi_pkg::MANT_W-1:0];
    assign log_done   = log_busy_reg && log_phase_reg && (log_iter_reg == 4'hF);
    assign log_result = {log_e_reg, log_frac_reg[lfgi_pkg::FRAC_W-2:0], log_bit};

    // Interpolation terms.
    assign den  = lr_reg - ll_reg;
    assign num  = (lq_reg <= ll_reg) ? '0 :
                  ((lq_reg - ll_reg) > den) ? den : (lq_reg - ll_reg);
    assign diff = lfgi_pkg::DIFF_W'(gr_reg) - lfgi_pkg::DIFF_W'(gl_reg);
    assign p_mag = p_reg[lfgi_pkg::MUL_W-1] ? lfgi_pkg::DIV_W'(-p_reg)
                                            : lfgi_pkg::DIV_W'(p_reg);

    assign trial    = {rem_reg[lfgi_pkg::LOG_W-1:0], quo_reg[lfgi_pkg::DIV_W-1]};
    assign trial_ge = trial >= {1'b0, den};
    assign div_done = div_busy_reg && (div_cnt_reg == lfgi_pkg::DCNT_W'(lfgi_pkg::DIV_W - 1));

    // Quotient is bounded by the gain difference, so its low bits carry it all.
    assign d_mag = quo_reg[lfgi_pkg::QUO_W-1:0];
    always_comb
    begin
        if (p_reg[lfgi_pkg::MUL_W-1])
        begin
            sum = lfgi_pkg::SUM_W'(gl_reg) - lfgi_pkg::SUM_W'(d_mag);
        end
        else
        begin
            sum = lfgi_pkg::SUM_W'(gl_reg) + lfgi_pkg::SUM_W'(d_mag);
        end
        if (sum > lfgi_pkg::SUM_W'(32767))
        begin
            interp = 16'sh7FFF;
        end
        else if (sum < -lfgi_pkg::SUM_W'(32768))
        begin
            interp = 16'sh8000;
        end
        else
        begin
            interp = sum[lfgi_pkg::GAIN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (cmd.res_sel)
            lfgi_pkg::RS_RDGAIN: res_gain = gain_rd;
            lfgi_pkg::RS_GL:     res_gain = gl_reg;
            lfgi_pkg::RS_GR:     res_gain = gr_reg;
            lfgi_pkg::RS_INTERP: res_gain = interp;
            default:             res_gain = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            log_busy_reg   <= 1'b0;
            log_phase_reg  <= 1'b0;
            log_iter_reg   <= '0;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.log_start)
            begin
                log_busy_reg  <= 1'b1;
                log_phase_reg <= 1'b0;
                log_iter_reg  <= '0;
            end
            else if (log_busy_reg)
            begin
                log_phase_reg <= ~log_phase_reg;
                if (log_phase_reg)
                begin
                    log_iter_reg <= log_iter_reg + 1'b1;
                end
                if (log_done)
                begin
                    log_busy_reg <= 1'b0;
                end
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_done)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            q_reg <= query_freq;
        end
        if (cmd.r_clr)
        begin
            r_reg <= '0;
        end
        else if (cmd.r_inc)
        begin
            r_reg <= r_reg + 1'b1;
        end
        if (cmd.save_right)
        begin
            fr_reg <= freq_rd;
            gr_reg <= gain_rd;
        end
        if (cmd.save_left)
        begin
            fl_reg <= freq_rd;
            gl_reg <= gain_rd;
        end
        if (log_done)
        begin
            unique case (log_sel_reg)
                lfgi_pkg::LS_RIGHT: lr_reg <= log_result;
                lfgi_pkg::LS_QUERY: lq_reg <= log_result;
                default:            ll_reg <= log_result;
            endcase
        end
        if (cmd.log_start)
        begin
            log_sel_reg  <= cmd.log_sel;
            log_e_reg    <= log_e;
            log_frac_reg <= '0;
            log_y_reg    <= log_mant[lfgi_pkg::FREQ_W-1:1];
        end
        else if (log_busy_reg && !log_phase_reg)
        begin
            log_prod_reg <= lfgi_pkg::PROD_W'(log_y_reg) * lfgi_pkg::PROD_W'(log_y_reg);
        end
        else if (log_busy_reg)
        begin
            log_y_reg    <= log_y_next;
            log_frac_reg <= {log_frac_reg[lfgi_pkg::FRAC_W-2:0], log_bit};
        end
        if (cmd.mul)
        begin
            p_reg <= $signed({1'b0, num}) * diff;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= p_mag + lfgi_pkg::DIV_W'(den >> 1);
        end
        else if (div_busy_reg)
        begin
            rem_reg <= trial_ge ? (trial - {1'b0, den}) : trial;
            quo_reg <= {quo_reg[lfgi_pkg::DIV_W-2:0], trial_ge};
        end
        if (cmd.res_load)
        begin
            res_gain_reg   <= res_gain;
            res_region_reg <= cmd.res_region;
        end
        if (cmd.out_load)
        begin
            out_gain_reg   <= res_gain_reg;
            out_region_reg <= res_region_reg;
        end
    end

    assign sts.cnt_zero  = (cnt == '0);
    assign sts.r_at_cnt  = (r_reg == cnt);
    assign sts.r_zero    = (r_reg == '0);
    assign sts.freq_ge_q = (freq_rd >= q_reg);
    assign sts.gains_eq  = (gl_reg == gr_reg);
    assign sts.log_done  = log_done;
    assign sts.lr_le_ll  = (lr_reg <= ll_reg);
    assign sts.div_done  = div_done;
    assign sts.out_busy  = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign out_gain   = out_gain_reg;
    assign out_region = out_region_reg;

endmodule

[hw/rtl/lfgi_checker.sv]
// Port-level assertions for the log-frequency gain interpolator, bound to the top level.
// Depends on lfgi_pkg and log_freq_gain_interpolator.
`timescale 1ns / 1ps

module lfgi_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               in_action,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [lfgi_pkg::GAIN_W-1:0] out_gain,
    input logic [1:0]                         out_region
);

    // A stalled result holds its valid and payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_gain) && $stable(out_region))
        else $error("output changed while stalled");

    // An empty table always answers 0 dB.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_region == lfgi_pkg::REG_EMPTY) |-> (out_gain == '0))
        else $error("empty region with nonzero gain");

    // A query is never finished in its accept cycle, so input is closed next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action |=> !in_ready)
        else $error("input open right after a query");

    // A load leaves the block ready for another transaction.
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_action |=> in_ready)
        else $error("input closed after a load");

endmodule

bind log_freq_gain_interpolator lfgi_checker u_lfgi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_gain   (out_ch.gain),
    .out_region (out_ch.region)
);

[tb/log_freq_gain_interpolator_tb.sv]
// Self-checking testbench for the log-frequency gain interpolator.
// Depends on lfgi_pkg, the lfgi_in_if/lfgi_out_if channels and the top-level RTL.
`timescale 1ns / 1ps

module log_freq_gain_interpolator_tb;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int ITEM_TARGET  = 540;

    typedef struct {
        logic        action;
        logic [7:0]  idx;
        logic [31:0] nfreq;
        logic [15:0] ngain;
        logic [31:0] qfreq;
    } req_t;

    typedef struct {
        logic signed [15:0] gain;
        lfgi_pkg::region_t  region;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [lfgi_pkg::CNT_W-1:0] cfg_wdata = '0;

    lfgi_in_if  in_ch ();
    lfgi_out_if out_ch ();

    log_freq_gain_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #5 clk = ~clk;

    // Shadow of the block: node tables and node count as the block sees them.
    logic [31:0]        node_freq_mem [lfgi_pkg::MAX_NODES];
    logic signed [15:0] node_gain_mem [lfgi_pkg::MAX_NODES];
    logic [8:0]         node_count_shadow = '0;

    // Planned table contents, updated when a transaction is queued, so that
    // query frequencies can be aimed at nodes before the loads are accepted.
    logic [31:0] plan_freq [lfgi_pkg::MAX_NODES];

    req_t    pending_reqs [$];
    answer_t expected_answers [$];

    int  errors = 0;
    int  cycles = 0;
    int  queued_items = 0;
    int  queries_sent = 0;
    int  answers_seen = 0;
    int  region_hits [4] = '{0, 0, 0, 0};
    bit  driver_busy = 0;
    bit  req_taken = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  long_stall = 0;
    bit  long_stall_done = 0;
    req_t cur_req;

    // Most gaps are zero or short; now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 13)
            return 0;
        else if (roll < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Fixed-point log2 as Q5.16: exponent from the leading one, fraction bits
    // from repeated squaring of a Q1.30 mantissa.
    function automatic logic [20:0] log2_fixed(logic [31:0] x);
        int unsigned e;
        logic [63:0] m;
        logic [15:0] frac;
        if (x == 0)
            x = 1;
        e = 0;
        while (e < 31 && (x >> (e + 1)) != 0)
            e++;
        m = ({32'b0, x} << 30) >> e;
        frac = '0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= (64'd2 << 30))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {e[4:0], frac};
    endfunction

    // Works out the gain and region for one query against the shadow tables.
    function automatic answer_t interpolate_gain(logic [31:0] q);
        answer_t a;
        int      n;
        int      r;
        longint  gl, gr, ll, lr, lq, den, num, p, d, s;
        n = (node_count_shadow > lfgi_pkg::MAX_NODES) ? lfgi_pkg::MAX_NODES
                                                      : node_count_shadow;
        r = 0;
        while (r < n && node_freq_mem[r] < q)
            r++;
        if (n == 0)
        begin
            a.gain = 0;
            a.region = lfgi_pkg::REG_EMPTY;
        end
        else if (r == 0)
        begin
            a.gain = node_gain_mem[0];
            a.region = lfgi_pkg::REG_BELOW;
        end
        else if (r == n)
        begin
            a.gain = node_gain_mem[n - 1];
            a.region = lfgi_pkg::REG_ABOVE;
        end
        else
        begin
            a.region = lfgi_pkg::REG_INTERP;
            gl = node_gain_mem[r - 1];
            gr = node_gain_mem[r];
            if (gl == gr)
                a.gain = gl[15:0];
            else
            begin
                ll = log2_fixed(node_freq_mem[r - 1]);
                lr = log2_fixed(node_freq_mem[r]);
                lq = log2_fixed(q);
                if (lr <= ll)
                    a.gain = gr[15:0];
                else
                begin
                    den = lr - ll;
                    num = (lq > ll) ? lq - ll : 0;
                    if (num > den)
                        num = den;
                    p = num * (gr - gl);
                    if (p >= 0)
                        d = (p + den / 2) / den;
                    else
                        d = -((-p + den / 2) / den);
                    s = gl + d;
                    if (s > 32767)
                        s = 32767;
                    else if (s < -32768)
                        s = -32768;
                    a.gain = s[15:0];
                end
            end
        end
        return a;
    endfunction

    task automatic queue_load(input int idx, input logic [31:0] f, input logic [15:0] g);
        req_t t;
        t.action = 1'b0;
        t.idx = idx[7:0];
        t.nfreq = f;
        t.ngain = g;
        t.qfreq = $urandom();
        plan_freq[idx] = f;
        pending_reqs.push_back(t);
        queued_items++;
    endtask

    task automatic queue_query(input logic [31:0] q);
        req_t t;
        t.action = 1'b1;
        t.idx = $urandom();
        t.nfreq = $urandom();
        t.ngain = $urandom();
        t.qfreq = q;
        pending_reqs.push_back(t);
        queued_items++;
    endtask

    // Waits until every queued transaction is accepted and every answer has
    // come back, then lets trailing loads settle inside the block.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || driver_busy || expected_answers.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_node_count(input int n);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= n[lfgi_pkg::CNT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        node_count_shadow = n[8:0];
    endtask

    // Loads slots 0..n-1 with ascending frequencies; steps mix tiny, zero and
    // wide spacings, and gains often repeat or sit at minus infinity.
    task automatic load_sorted_table(input int n);
        longint      f;
        logic [15:0] g;
        logic [15:0] prev_g;
        int          roll;
        f = $urandom_range(1, 4000);
        prev_g = 0;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 9);
            if (i > 0)
            begin
                if (roll == 0)
                    f = f;
                else if (roll < 3)
                    f = f + $urandom_range(1, 3);
                else
                    f = f + $urandom_range(1, (n > 64) ? (1 << 24) : (1 << 27));
            end
            if (f > 64'hFFFF_FFFF)
                f = 64'hFFFF_FFFF;
            roll = $urandom_range(0, 9);
            if (roll < 2 && i > 0)
                g = prev_g;
            else if (roll == 2)
                g = 16'h8000;
            else if (roll == 3)
                g = 16'h7FFF;
            else
                g = $urandom();
            prev_g = g;
            queue_load(i, f[31:0], g);
        end
    endtask

    // Aims a query at the planned table: exact node hits, points between
    // neighbors, and the far ends of the frequency range.
    function automatic logic [31:0] pick_query_freq(input int n);
        int          roll;
        int          k;
        logic [31:0] f;
        roll = $urandom_range(0, 9);
        if (n == 0 || roll == 0)
            return $urandom();
        k = $urandom_range(0, n - 1);
        f = plan_freq[k];
        case (roll)
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3, 4: return f;
            5: return f - 1;
            default:
            begin
                if (k + 1 < n && plan_freq[k + 1] > f)
                    return f + $urandom_range(0, plan_freq[k + 1] - f);
                return f + $urandom_range(0, 1000);
            end
        endcase
    endfunction

    // Sender: presents one transaction at a time from the pending queue and
    // inserts random gaps between transactions.
    always @(negedge clk)
    begin
        logic v;
        v = in_ch.valid;
        if (req_taken)
        begin
            req_taken = 0;
            v = 1'b0;
            driver_busy = 0;
        end
        if (rst_n && !v)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_reqs.size() != 0)
            begin
                cur_req = pending_reqs.pop_front();
                in_ch.action <= cur_req.action;
                in_ch.node_index <= cur_req.idx;
                in_ch.node_freq <= cur_req.nfreq;
                in_ch.node_gain <= cur_req.ngain;
                in_ch.query_freq <= cur_req.qfreq;
                v = 1'b1;
                driver_busy = 1;
                send_gap = pick_gap();
            end
        end
        in_ch.valid <= v;
    end

    // Input side: every accepted transaction updates the shadow or queues an answer.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            req_taken = 1;
            if (cur_req.action == 1'b0)
            begin
                node_freq_mem[cur_req.idx] = cur_req.nfreq;
                node_gain_mem[cur_req.idx] = cur_req.ngain;
            end
            else
            begin
                expected_answers.push_back(interpolate_gain(cur_req.qfreq));
                queries_sent++;
            end
        end
    end

    // Output side: compare each answer with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            answers_seen++;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected answer gain=%0d region=%0d",
                         $time, out_ch.gain, out_ch.region);
                errors++;
            end
            else
            begin
                e = expected_answers.pop_front();
                region_hits[e.region]++;
                if (out_ch.gain !== e.gain)
                begin
                    $display("%0t: gain mismatch: expected %0d, actual %0d",
                             $time, e.gain, out_ch.gain);
                    errors++;
                end
                if (out_ch.region !== e.region)
                begin
                    $display("%0t: region mismatch: expected %0d, actual %0d",
                             $time, e.region, out_ch.region);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off after some answers,
    // started while the sender still has work queued, so that the output
    // register stays full and the input side backs up.
    always @(negedge clk)
    begin
        logic rdy;
        rdy = 1'b0;
        if (rst_n)
        begin
            if (!long_stall_done && answers_seen >= 40 && pending_reqs.size() > 4)
            begin
                long_stall_done = 1;
                long_stall = 3000;
            end
            if (long_stall > 0)
                long_stall--;
            else if (recv_gap > 0)
                recv_gap--;
            else
            begin
                rdy = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap = pick_gap();
            end
        end
        out_ch.ready <= rdy;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        int eff;
        int nq;
        int roll;
        bit first_phase;

        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.node_index = '0;
        in_ch.node_freq = '0;
        in_ch.node_gain = '0;
        in_ch.query_freq = '0;
        out_ch.ready = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. An empty table answers 0 dB regardless of frequency.
        write_node_count(0);
        queue_query(32'd1);
        queue_query(32'hFFFF_FFFF);

        // Node 0 at the lowest frequency, a minus-infinity pair, a mixed pair
        // and a final pair whose logs are equal.
        queue_load(0, 32'd1, 16'h7FFF);
        queue_load(1, 32'd25600, 16'h8000);
        queue_load(2, 32'd256000, 16'h8000);
        queue_load(3, 32'hFFFF_FFFE, 16'd1200);
        queue_load(4, 32'hFFFF_FFFF, 16'hFE0C);
        write_node_count(5);
        queue_query(32'd0);
        queue_query(32'd1);
        queue_query(32'd2);
        queue_query(32'd25600);
        queue_query(32'd100000);
        queue_query(32'd300000);
        queue_query(32'hFFFF_FFFE);
        queue_query(32'hFFFF_FFFF);

        // Three nodes: beyond the last node and a steep interpolation.
        write_node_count(3);
        queue_query(32'hFFFF_FFFF);
        queue_query(32'd5000);
        queue_query(32'd256000);

        // Random part: phases with their own node count. The first phase uses
        // a count above the table size, so every slot is in play; the later
        // tables are short.
        first_phase = 1;
        while (queued_items < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 19);
            if (first_phase)
                n = $urandom_range(257, 511);
            else if (roll == 0)
                n = 0;
            else if (roll == 3)
                n = 2;
            else
                n = $urandom_range(1, 12);
            first_phase = 0;
            eff = (n > lfgi_pkg::MAX_NODES) ? lfgi_pkg::MAX_NODES : n;
            write_node_count(n);
            load_sorted_table(eff);
            nq = (eff > 32) ? 8 : $urandom_range(15, 40);
            for (int i = 0; i < nq; i++)
            begin
                // Occasional rewrites of a used slot, which may unsort the table.
                if (eff > 0 && $urandom_range(0, 5) == 0)
                    queue_load($urandom_range(0, eff - 1), pick_query_freq(eff),
                               16'($urandom()));
                queue_query(pick_query_freq(eff));
            end
        end

        write_node_count(511);
        drain();

        $display("Covered %0d transactions, %0d queries; regions empty/below/above/interp:",
                 queued_items, queries_sent);
        $display("  %0d / %0d / %0d / %0d, with one long receiver hold-off",
                 region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
